/* src/spm_pkg.sv */
// Shared types and constants for the spindle PWM command mapper.
// No dependencies.
package spm_pkg;

	localparam int SPEED_W = 16;
	localparam int FREQ_W = 16;
	localparam int DUTY_W = 17;
	localparam int PER_W = 16;
	localparam int NUM_W = 27;
	localparam int DUTY_QW = 17;
	localparam int N_CELLS = NUM_W;
	localparam int DUTY_FIRST = NUM_W - DUTY_QW;
	localparam int PROD_W = SPEED_W + DUTY_W;
	localparam int CPU_CLOCK_HZ_DEF = 32000000;
	localparam logic [DUTY_W-1:0] FULL_DUTY = 17'd65536;
	localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd1000;

	localparam int IN_W = 24;
	localparam int OUT_W = 40;
	localparam int CFG_W = 17;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_PWM_FREQ = 3'd0,
		REG_MIN_RPM = 3'd1,
		REG_MAX_RPM = 3'd2,
		REG_DUTY_LO = 3'd3,
		REG_DUTY_HI = 3'd4,
		REG_DIR_REV = 3'd5,
		REG_EN_LOW = 3'd6,
		REG_PWM_LOW = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		CSEL_OFF = 3'd0,
		CSEL_DIV1 = 3'd1,
		CSEL_DIV2 = 3'd2,
		CSEL_DIV4 = 3'd3,
		CSEL_DIV8 = 3'd4,
		CSEL_DIV64 = 3'd5
	} csel_t;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_CW = 2'd1;

	typedef struct packed {
		logic [FREQ_W-1:0] pwm_freq_hz;
		logic [SPEED_W-1:0] min_rpm;
		logic [SPEED_W-1:0] max_rpm;
		logic [DUTY_W-1:0] duty_lo;
		logic [DUTY_W-1:0] duty_hi;
		logic dir_reverse;
		logic enable_active_low;
		logic pwm_active_low;
	} cfg_t;

	typedef struct packed {
		logic active;
		logic force_high;
		logic degen;
		logic down;
		logic [DUTY_W-1:0] duty_lo;
		logic [DUTY_W-1:0] duty_hi;
		logic dir_pin;
		logic enable_inv;
		logic pwm_inv;
	} side_t;

	typedef struct packed {
		logic [PER_W-1:0] prem;
		logic [NUM_W-1:0] pnum;
		logic [FREQ_W-1:0] freq;
		logic [SPEED_W-1:0] drem;
		logic [DUTY_QW-1:0] dnum;
		logic [SPEED_W-1:0] range;
		side_t side;
	} cell_t;

endpackage

/* src/spm_div_cell.sv */
// One restoring-division cell: a period quotient bit and optionally a duty quotient bit.
// Depends on spm_pkg.
module spm_div_cell import spm_pkg::*; #(
	parameter bit DO_DUTY = 1'b1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input cell_t in_cell,
	output logic out_valid,
	output cell_t out_cell
);

	cell_t nxt;
	logic [PER_W:0] pt;
	logic [SPEED_W:0] dt;
	logic pge, dge;

	always_comb begin
		nxt = in_cell;
		pt = {in_cell.prem, in_cell.pnum[NUM_W-1]};
		pge = pt >= {1'b0, in_cell.freq};
		nxt.prem = pge ? PER_W'(pt - {1'b0, in_cell.freq}) : pt[PER_W-1:0];
		nxt.pnum = {in_cell.pnum[NUM_W-2:0], pge};
		dt = {in_cell.drem, in_cell.dnum[DUTY_QW-1]};
		dge = dt >= {1'b0, in_cell.range};
		if (DO_DUTY) begin
			nxt.drem = dge ? SPEED_W'(dt - {1'b0, in_cell.range}) : dt[SPEED_W-1:0];
			nxt.dnum = {in_cell.dnum[DUTY_QW-2:0], dge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) out_cell <= nxt;
	end

endmodule

/* src/spm_front.sv */
// Command decode, speed clamp and duty numerator product feeding the divider chain.
// Depends on spm_pkg.
module spm_front import spm_pkg::*; #(
	parameter int unsigned CPU_CLOCK_HZ = CPU_CLOCK_HZ_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [1:0] spin_mode,
	input logic [SPEED_W-1:0] speed_rpm,
	input logic estop_active,
	input cfg_t cfg,
	output logic out_valid,
	output cell_t out_cell
);

	logic valid_s1;
	logic [SPEED_W-1:0] off_s1, range_s1;
	logic [DUTY_W-1:0] span_s1;
	logic [FREQ_W-1:0] freq_s1;
	side_t side_s1;

	side_t sd;
	logic [SPEED_W-1:0] spd_c, off, range;
	logic [DUTY_W-1:0] span;
	logic [PROD_W-1:0] prod;

	always_comb begin
		sd.active = (spin_mode != MODE_OFF) && (speed_rpm >= cfg.min_rpm) && !estop_active;
		sd.force_high = sd.active && (speed_rpm >= cfg.max_rpm) && (cfg.duty_hi == FULL_DUTY);
		sd.degen = cfg.max_rpm <= cfg.min_rpm;
		sd.down = cfg.duty_hi < cfg.duty_lo;
		sd.duty_lo = cfg.duty_lo;
		sd.duty_hi = cfg.duty_hi;
		sd.dir_pin = ~((spin_mode == MODE_CW) ^ cfg.dir_reverse);
		sd.enable_inv = cfg.enable_active_low;
		sd.pwm_inv = cfg.pwm_active_low;
		spd_c = (speed_rpm > cfg.max_rpm) ? cfg.max_rpm : speed_rpm;
		off = (sd.active && !sd.degen) ? SPEED_W'(spd_c - cfg.min_rpm) : '0;
		range = sd.degen ? SPEED_W'(1) : SPEED_W'(cfg.max_rpm - cfg.min_rpm);
		span = sd.down ? DUTY_W'(cfg.duty_lo - cfg.duty_hi)
			: DUTY_W'(cfg.duty_hi - cfg.duty_lo);
		prod = PROD_W'(off_s1) * PROD_W'(span_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= off;
			range_s1 <= range;
			span_s1 <= span;
			freq_s1 <= cfg.pwm_freq_hz;
			side_s1 <= sd;
			out_cell.prem <= '0;
			out_cell.pnum <= NUM_W'(CPU_CLOCK_HZ);
			out_cell.freq <= freq_s1;
			out_cell.drem <= prod[PROD_W-1:DUTY_QW];
			out_cell.dnum <= prod[DUTY_QW-1:0];
			out_cell.range <= range_s1;
			out_cell.side <= side_s1;
		end
	end

endmodule

/* src/spm_back.sv */
// Prescaler pick, duty finish, compare product and output register.
// Depends on spm_pkg.
module spm_back import spm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input cell_t in_cell,
	output logic out_valid,
	output logic [OUT_W-1:0] out_data
);

	logic valid_e1;
	csel_t csel_e1;
	logic [PER_W-1:0] per_e1;
	logic [DUTY_W-1:0] duty_e1;
	logic force_e1, dir_e1, eninv_e1, pwminv_e1;

	csel_t csel;
	logic [PER_W-1:0] per;
	logic [DUTY_W-1:0] duty;
	logic [NUM_W-1:0] q, q2, q4, q8, q64;
	logic [PROD_W-1:0] prod;
	logic [PER_W-1:0] cmp;
	logic running;
	side_t sd;

	always_comb begin
		sd = in_cell.side;
		q = in_cell.pnum;
		q2 = q >> 1;
		q4 = q >> 2;
		q8 = q >> 3;
		q64 = q >> 6;
		csel = CSEL_OFF;
		per = '0;
		if (!sd.active || sd.force_high || in_cell.freq == '0) begin
			csel = CSEL_OFF;
		end else if (q[NUM_W-1:PER_W] == '0) begin
			csel = CSEL_DIV1;
			per = q[PER_W-1:0];
		end else if (q2[NUM_W-1:PER_W] == '0) begin
			csel = CSEL_DIV2;
			per = q2[PER_W-1:0];
		end else if (q4[NUM_W-1:PER_W] == '0) begin
			csel = CSEL_DIV4;
			per = q4[PER_W-1:0];
		end else if (q8[NUM_W-1:PER_W] == '0) begin
			csel = CSEL_DIV8;
			per = q8[PER_W-1:0];
		end else if (q64[NUM_W-1:PER_W] == '0) begin
			csel = CSEL_DIV64;
			per = q64[PER_W-1:0];
		end
		if (sd.degen) duty = sd.duty_hi;
		else if (sd.down) duty = DUTY_W'(sd.duty_lo - in_cell.dnum);
		else duty = DUTY_W'(sd.duty_lo + in_cell.dnum);
		prod = PROD_W'(per_e1) * PROD_W'(duty_e1);
		cmp = (prod[PROD_W-1:PER_W+PER_W] != '0) ? '1 : prod[PER_W+PER_W-1:PER_W];
		running = (csel_e1 != CSEL_OFF) || force_e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_e1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_e1 <= in_valid;
			out_valid <= valid_e1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csel_e1 <= csel;
			per_e1 <= per;
			duty_e1 <= duty;
			force_e1 <= sd.force_high;
			dir_e1 <= sd.dir_pin;
			eninv_e1 <= sd.enable_inv;
			pwminv_e1 <= sd.pwm_inv;
			out_data <= {1'b0, dir_e1, running ^ eninv_e1, pwminv_e1, force_e1,
				cmp, per_e1, csel_e1};
		end
	end

endmodule

/* src/spindle_pwm_command_mapper_core.sv */
// Spindle PWM command mapper: one result word per command word. The block is a
// pipeline of 31 register stages, a front of two, a row of 27 restoring-division cells
// that each produce one quotient bit of the timer period, the last 17 also one of the
// duty step, and a back of one plus the output register.
// It takes one word every cycle; the whole pipeline halts only while a result waits
// at the output. Configuration registers are read as a word enters.
// Depends on spm_pkg, spm_front, spm_div_cell and spm_back.
module spindle_pwm_command_mapper_core import spm_pkg::*; #(
	parameter int unsigned CPU_CLOCK_HZ = CPU_CLOCK_HZ_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [IN_W-1:0] s_tdata, // spin_mode[1:0], speed_rpm[17:2], estop_active[18]
	output logic m_tvalid,
	input logic m_tready,
	// clock_select, period_count, compare_count, force_high, pwm_pin_invert,
	// enable_pin, dir_pin
	output logic [OUT_W-1:0] m_tdata
);

	cfg_t cfg_q;
	logic adv;
	logic v [N_CELLS+1];
	cell_t c [N_CELLS+1];

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pwm_freq_hz: FREQ_RESET, default: '0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PWM_FREQ: cfg_q.pwm_freq_hz <= cfg_data[FREQ_W-1:0];
				REG_MIN_RPM: cfg_q.min_rpm <= cfg_data[SPEED_W-1:0];
				REG_MAX_RPM: cfg_q.max_rpm <= cfg_data[SPEED_W-1:0];
				REG_DUTY_LO: cfg_q.duty_lo <= cfg_data[DUTY_W-1:0];
				REG_DUTY_HI: cfg_q.duty_hi <= cfg_data[DUTY_W-1:0];
				REG_DIR_REV: cfg_q.dir_reverse <= cfg_data[0];
				REG_EN_LOW: cfg_q.enable_active_low <= cfg_data[0];
				REG_PWM_LOW: cfg_q.pwm_active_low <= cfg_data[0];
				default: ;
			endcase
		end
	end

	spm_front #(.CPU_CLOCK_HZ(CPU_CLOCK_HZ)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(s_tvalid),
		.spin_mode(s_tdata[1:0]),
		.speed_rpm(s_tdata[17:2]),
		.estop_active(s_tdata[18]),
		.cfg(cfg_q),
		.out_valid(v[0]),
		.out_cell(c[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		spm_div_cell #(.DO_DUTY(i >= DUTY_FIRST)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.in_valid(v[i]),
			.in_cell(c[i]),
			.out_valid(v[i+1]),
			.out_cell(c[i+1])
		);
	end

	spm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v[N_CELLS]),
		.in_cell(c[N_CELLS]),
		.out_valid(m_tvalid),
		.out_data(m_tdata)
	);

endmodule

/* src/spm_checker.sv */
// Port-level checks for the spindle PWM command mapper, bound to the top level.
// Depends on spm_pkg.
module spm_checker import spm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	a_force_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> m_tdata[2:0] == CSEL_OFF && m_tdata[18:3] == '0)
		else $error("forced-high word has timer running");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == CSEL_OFF |-> m_tdata[18:3] == '0 && m_tdata[34:19] == '0)
		else $error("timer off but counts nonzero");

	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

endmodule

bind spindle_pwm_command_mapper_core spm_checker u_spm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
